FILE: rtl/rolling_zscore_window_top_macros.svh
// rolling_zscore_window_top_macros.svh: assertion macros for the z-score block
// no dependencies; included by the files that hold concurrent assertions
`ifndef ROLLING_ZSCORE_WINDOW_TOP_MACROS_SVH
`define ROLLING_ZSCORE_WINDOW_TOP_MACROS_SVH

// generic property check, disabled while in reset
`define RZW_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// a signal holds in the cycle after a condition
`define RZW_ASSERT_HOLD(lbl, clk, rstn, cond, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> $stable(sig)) \
    else $error(msg);

`endif

FILE: rtl/rzw_pkg.sv
// rzw_pkg: types and constants of the rolling z-score block
// no dependencies; used by the interfaces and the top level
`default_nettype none

package rzw_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int CFG_W      = 11;
  localparam int Z_W        = 24;
  localparam int ROOT_W     = 24;
  localparam int DIV_BITS   = 2 * ROOT_W;
  localparam int FRAC_SHIFT = 32;

  localparam logic [CFG_W-1:0] WIN_RESET   = 11'd20;
  localparam logic [Z_W-1:0]   Z_POS_LIMIT = 24'h7F_FFFF;
  localparam logic [Z_W-1:0]   Z_NEG_LIMIT = 24'h80_0000;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UPD,
    ST_ADDSQ,
    ST_SUBSQ,
    ST_NUM,
    ST_MUL,
    ST_MULDONE,
    ST_DIV,
    ST_SQRT,
    ST_FIN
  } rzw_state_e;

  // which product the serial multiplier is forming
  typedef enum logic [1:0] {
    MUL_SS,
    MUL_WQ,
    MUL_NUM
  } rzw_mul_e;

endpackage

`default_nettype wire

FILE: rtl/rzw_if.sv
// rzw_if: valid/ready channels of the rolling z-score block
// depends on rzw_pkg for field widths
`default_nettype none

interface rzw_in_if;
  import rzw_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last;
  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

interface rzw_out_if;
  import rzw_pkg::*;
  logic                  valid;
  logic                  ready;
  logic signed [Z_W-1:0] zscore;
  logic                  filled;
  logic                  last_out;
  modport source (output valid, output zscore, output filled, output last_out, input ready);
  modport sink   (input valid, input zscore, input filled, input last_out, output ready);
endinterface

interface rzw_cfg_if;
  import rzw_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] win_len;
  modport source (output valid, output win_len, input ready);
  modport sink   (input valid, input win_len, output ready);
endinterface

`default_nettype wire

FILE: rtl/rolling_zscore_window_top.sv
// rolling_zscore_window_top: rolling z-score over a sliding sample window
// depends on rzw_pkg and the channel interfaces in rzw_if
//
// Usage:
//   in_i carries one Q12.12 sample word and a last flag; out_o returns one
//   word per input: Q8.16 z-score, filled flag and the copied last flag.
//   cfg_i writes the window length; a write also starts a new series. Write
//   it only while the block is idle.
// Sequencing:
//   one word at a time. A word that is not scored goes from the square
//   updates straight to the output stage. A scored word runs three
//   bit-serial products of NW steps each, NW = clog2(MAX_WINDOW+1) + 26,
//   on one shared shift-add multiplier (a zero variance ends the word
//   after the second), then 48 restoring divide steps (skipped when the
//   quotient overflows) and 24 square root steps, one bit per cycle.
// Reset:
//   clears sums, sample count and ring pointer, the window length returns
//   to 20; the history memory is not cleared, only slots written in the
//   current series are used.
// Stall:
//   a finished word waits in the output register; the next input word is
//   accepted while it waits, and its result waits in the sequencer until
//   the output register frees.
`default_nettype none

module rolling_zscore_window_top #(
  parameter int MAX_WINDOW = 1024
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  rzw_cfg_if.sink   cfg_i,
  rzw_in_if.sink    in_i,
  rzw_out_if.source out_o
);
  import rzw_pkg::*;

  localparam int AW   = $clog2(MAX_WINDOW);
  localparam int CW   = $clog2(MAX_WINDOW + 1);
  localparam int XW   = (CW > CFG_W) ? CW : CFG_W;
  localparam int OW   = CW + 1;
  localparam int SW   = CW + SAMPLE_W;
  localparam int QW   = CW + 2 * SAMPLE_W - 1;
  localparam int NW   = SW + 2;
  localparam int DW   = 2 * SW;
  localparam int WQW  = CW + QW;
  localparam int VW   = (DW > WQW) ? DW : WQW;
  localparam int AMW  = (QW > NW) ? QW : NW;
  localparam int PW   = AMW + NW;
  localparam int RW0  = 2 * NW + FRAC_SHIFT;
  localparam int RW1  = VW + DIV_BITS;
  localparam int RW   = ((RW0 > RW1) ? RW0 : RW1) + 1;
  localparam int LO_CUT = DIV_BITS - FRAC_SHIFT;
  localparam int MAXC = (NW > DIV_BITS) ? NW : DIV_BITS;
  localparam int CTW  = $clog2(MAXC + 1);
  localparam int RMW  = ROOT_W + 2;
  localparam int PSQ  = 2 * SAMPLE_W;

  // control state
  rzw_state_e       state_q, state_d;
  rzw_mul_e         mul_id_q;
  logic [CFG_W-1:0] win_q;
  logic signed [SW-1:0] sum_q;
  logic [QW-1:0]    sq_q;
  logic [CW-1:0]    seen_q;
  logic [AW-1:0]    slot_q;
  logic             out_valid_q;
  logic [CTW-1:0]   cnt_q;

  // working registers
  logic signed [SAMPLE_W-1:0] x_q, old_q;
  logic             last_q, ev_q, neg_q, zero_q, filled_q;
  logic [PSQ-1:0]   prod_q;
  logic signed [NW-1:0] num_q;
  logic [PW-1:0]    acc_q, ma_q;
  logic [NW-1:0]    mb_q;
  logic [VW-1:0]    ss_q, d_q, rem_q;
  logic [DIV_BITS-1:0] lo_q, qt_q;
  logic [RMW-1:0]   srem_q;
  logic [ROOT_W-1:0] root_q;
  logic signed [Z_W-1:0] z_q;
  logic             zf_q, zl_q;

  logic signed [SAMPLE_W-1:0] hist_mem [MAX_WINDOW];

  // combinational helpers
  logic [XW-1:0]    win_ext;
  logic [CW-1:0]    w_eff;
  logic [OW-1:0]    old_raw, old_sum;
  logic [AW-1:0]    old_idx, slot_inc;
  logic             in_acc, cfg_acc, out_acc, out_free;
  logic             evict, score_go, var_zero, mul_end, div_end, sqrt_end, ovf;
  logic signed [SW-1:0] sum_abs_s;
  logic [SW-1:0]    sum_abs;
  logic [NW-1:0]    num_abs;
  logic signed [NW-1:0] n_s, x_s;
  logic signed [PSQ-1:0] sqa, sqb;
  logic [VW-1:0]    wq_ext;
  logic [RW-1:0]    rhs_ext, dsh_ext;
  logic [VW:0]      rem_sh, rem_sub;
  logic [RMW-1:0]   srem_sh, trial;
  logic [Z_W-1:0]   mag, z_val;

  assign in_acc   = in_i.valid && in_i.ready;
  assign cfg_acc  = cfg_i.valid && cfg_i.ready;
  assign out_acc  = out_o.valid && out_o.ready;
  assign out_free = !out_valid_q || out_o.ready;

  // effective window, clamped to 1..MAX_WINDOW
  always_comb begin
    win_ext = XW'(win_q);
    if (win_ext == '0) begin
      w_eff = CW'(1);
    end else if (win_ext > XW'(MAX_WINDOW)) begin
      w_eff = CW'(MAX_WINDOW);
    end else begin
      w_eff = win_ext[CW-1:0];
    end
  end

  // ring slot of the sample leaving the window
  always_comb begin
    old_raw = OW'(slot_q) + OW'(MAX_WINDOW) - OW'(w_eff);
    old_sum = (old_raw >= OW'(MAX_WINDOW)) ? old_raw - OW'(MAX_WINDOW) : old_raw;
    old_idx = old_sum[AW-1:0];
    slot_inc = (slot_q == AW'(MAX_WINDOW - 1)) ? '0 : slot_q + AW'(1);
  end

  // flags and narrow arithmetic of the sequencer
  always_comb begin
    evict     = (seen_q >= w_eff);
    score_go  = (seen_q >= w_eff) || last_q;
    sum_abs_s = sum_q[SW-1] ? -sum_q : sum_q;
    sum_abs   = sum_abs_s;
    num_abs   = num_q[NW-1] ? NW'(-num_q) : NW'(num_q);
    n_s       = NW'($signed({1'b0, seen_q}));
    x_s       = NW'(x_q);
    sqa       = PSQ'(x_q);
    sqb       = PSQ'(old_q);
    wq_ext    = VW'(acc_q[WQW-1:0]);
    var_zero  = (ss_q >= wq_ext);
    rhs_ext   = RW'({acc_q[2*NW-1:0], {FRAC_SHIFT{1'b0}}});
    dsh_ext   = RW'({d_q, {DIV_BITS{1'b0}}});
    ovf       = (rhs_ext >= dsh_ext);
    mul_end   = (cnt_q == CTW'(NW - 1));
    div_end   = (cnt_q == CTW'(DIV_BITS - 1));
    sqrt_end  = (cnt_q == CTW'(ROOT_W - 1));
    rem_sh    = {rem_q, lo_q[DIV_BITS-1]};
    rem_sub   = rem_sh - {1'b0, d_q};
    srem_sh   = {srem_q[RMW-3:0], qt_q[DIV_BITS-1:DIV_BITS-2]};
    trial     = {root_q, 2'b01};
    if (neg_q) begin
      mag   = (root_q > Z_NEG_LIMIT) ? Z_NEG_LIMIT : root_q;
      z_val = ~mag + Z_W'(1);
    end else begin
      mag   = (root_q > Z_POS_LIMIT) ? Z_POS_LIMIT : root_q;
      z_val = mag;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (in_acc) state_d = ST_UPD;
      ST_UPD:     state_d = ST_ADDSQ;
      ST_ADDSQ:   state_d = ST_SUBSQ;
      ST_SUBSQ:   state_d = score_go ? ST_NUM : ST_FIN;
      ST_NUM:     state_d = ST_MUL;
      ST_MUL:     if (mul_end) state_d = ST_MULDONE;
      ST_MULDONE: begin
        case (mul_id_q)
          MUL_SS:  state_d = ST_MUL;
          MUL_WQ:  state_d = var_zero ? ST_FIN : ST_MUL;
          MUL_NUM: state_d = ovf ? ST_SQRT : ST_DIV;
          default: state_d = ST_FIN;
        endcase
      end
      ST_DIV:     if (div_end) state_d = ST_SQRT;
      ST_SQRT:    if (sqrt_end) state_d = ST_FIN;
      ST_FIN:     if (out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_i.ready   = (state_q == ST_IDLE);
    cfg_i.ready  = 1'b1;
    out_o.valid  = out_valid_q;
    out_o.zscore = z_q;
    out_o.filled = zf_q;
    out_o.last_out = zl_q;
  end

  // control registers and series state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mul_id_q    <= MUL_SS;
      win_q       <= WIN_RESET;
      sum_q       <= '0;
      sq_q        <= '0;
      seen_q      <= '0;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      // output word set on finish, cleared when taken
      if ((state_q == ST_FIN) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_UPD: begin
          sum_q  <= sum_q - (evict ? SW'(old_q) : SW'(0)) + SW'(x_q);
          seen_q <= evict ? seen_q : seen_q + CW'(1);
          slot_q <= slot_inc;
        end
        ST_ADDSQ: sq_q <= sq_q + QW'(prod_q);
        ST_SUBSQ: if (ev_q) sq_q <= sq_q - QW'(prod_q);
        ST_NUM: begin
          mul_id_q <= MUL_SS;
          cnt_q    <= '0;
        end
        ST_MUL: cnt_q <= cnt_q + CTW'(1);
        ST_MULDONE: begin
          cnt_q <= '0;
          if (mul_id_q == MUL_SS) mul_id_q <= MUL_WQ;
          else if (mul_id_q == MUL_WQ) mul_id_q <= MUL_NUM;
        end
        ST_DIV:  cnt_q <= div_end ? '0 : cnt_q + CTW'(1);
        ST_SQRT: cnt_q <= cnt_q + CTW'(1);
        ST_FIN: begin
          if (out_free && last_q) begin
            sum_q  <= '0;
            sq_q   <= '0;
            seen_q <= '0;
            slot_q <= '0;
          end
        end
        default: ;
      endcase
      // window write starts a new series
      if (cfg_acc) begin
        win_q  <= cfg_i.win_len;
        sum_q  <= '0;
        sq_q   <= '0;
        seen_q <= '0;
        slot_q <= '0;
      end
    end
  end

  // history ring, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (in_acc) old_q <= hist_mem[old_idx];
    if (state_q == ST_UPD) hist_mem[slot_q] <= x_q;
  end

  // datapath: squares, serial multiplier, divider and root
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          x_q    <= in_i.sample;
          last_q <= in_i.last;
        end
      end
      ST_UPD: begin
        ev_q   <= evict;
        prod_q <= PSQ'(sqa * sqa);
      end
      ST_ADDSQ: prod_q <= PSQ'(sqb * sqb);
      ST_SUBSQ: begin
        zero_q   <= 1'b1;
        filled_q <= score_go;
        num_q    <= n_s * x_s - NW'(sum_q);
      end
      ST_NUM: begin
        // start |S|*|S|
        acc_q <= '0;
        ma_q  <= PW'(sum_abs);
        mb_q  <= NW'(sum_abs);
        neg_q <= num_q[NW-1];
      end
      ST_MUL: begin
        if (mb_q[0]) acc_q <= acc_q + ma_q;
        ma_q <= {ma_q[PW-2:0], 1'b0};
        mb_q <= {1'b0, mb_q[NW-1:1]};
      end
      ST_MULDONE: begin
        case (mul_id_q)
          MUL_SS: begin
            ss_q  <= VW'(acc_q[DW-1:0]);
            acc_q <= '0;
            ma_q  <= PW'(sq_q);
            mb_q  <= NW'(seen_q);
          end
          MUL_WQ: begin
            d_q   <= wq_ext - ss_q;
            acc_q <= '0;
            ma_q  <= PW'(num_abs);
            mb_q  <= num_abs;
          end
          MUL_NUM: begin
            zero_q <= 1'b0;
            rem_q  <= VW'(acc_q[2*NW-1:LO_CUT]);
            lo_q   <= {acc_q[LO_CUT-1:0], {FRAC_SHIFT{1'b0}}};
            qt_q   <= ovf ? '1 : '0;
            srem_q <= '0;
            root_q <= '0;
          end
          default: ;
        endcase
      end
      ST_DIV: begin
        // one quotient bit per cycle
        if (!rem_sub[VW]) begin
          rem_q <= rem_sub[VW-1:0];
          qt_q  <= {qt_q[DIV_BITS-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh[VW-1:0];
          qt_q  <= {qt_q[DIV_BITS-2:0], 1'b0};
        end
        lo_q <= {lo_q[DIV_BITS-2:0], 1'b0};
      end
      ST_SQRT: begin
        // one root bit per cycle
        if (srem_sh >= trial) begin
          srem_q <= srem_sh - trial;
          root_q <= {root_q[ROOT_W-2:0], 1'b1};
        end else begin
          srem_q <= srem_sh;
          root_q <= {root_q[ROOT_W-2:0], 1'b0};
        end
        qt_q <= {qt_q[DIV_BITS-3:0], 2'b00};
      end
      ST_FIN: begin
        if (out_free) begin
          z_q  <= zero_q ? '0 : z_val;
          zf_q <= filled_q;
          zl_q <= last_q;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/rzw_checker.sv
// rzw_checker: port-level assertions of the rolling z-score block
// depends on rolling_zscore_window_top_macros.svh; bound to the top level
`default_nettype none

`include "rolling_zscore_window_top_macros.svh"

module rzw_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_ready_i,
  input wire        out_valid_i,
  input wire        out_ready_i,
  input wire [23:0] out_zscore_i,
  input wire        out_filled_i,
  input wire        out_last_i
);

  // one word in work at a time
  `RZW_ASSERT(a_one_word, clk_i, rst_ni, (in_valid_i && in_ready_i) |=> !in_ready_i, "input taken while busy")

  // an unscored word carries a zero score
  `RZW_ASSERT(a_unfilled_zero, clk_i, rst_ni, (out_valid_i && !out_filled_i) |-> (out_zscore_i == 24'd0), "nonzero score without fill")

  // a stalled word stays offered
  `RZW_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_i && !out_ready_i) |=> out_valid_i, "output word dropped")

  // a stalled word keeps its payload
  `RZW_ASSERT_HOLD(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, {out_zscore_i, out_filled_i, out_last_i}, "output payload changed")

endmodule

bind rolling_zscore_window_top rzw_checker u_rzw_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_zscore_i (out_o.zscore),
  .out_filled_i (out_o.filled),
  .out_last_i   (out_o.last_out)
);

`default_nettype wire
